// ===== rtl/ip6tap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ip6tap_pkg
// Shared types and character codes for the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ip6tap_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   localparam int unsigned NUM_GROUPS = 8;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_HEX,
      PH_V4,
      PH_FAIL
   } phase_type;

   // Parser state as seen by the end-of-string logic.
   typedef struct packed {
      phase_type         phase;
      logic [7:0][15:0]  grp;
      logic [3:0]        cnt;
      logic [3:0]        gap_pos;
      logic              gap_seen;
      logic [15:0]       hex;
      logic              has_digit;
      logic              prev_colon;
      logic [1:0]        oct_idx;
      logic [7:0]        oct_val;
      logic              oct_has;
      logic [2:0][7:0]   v4b;
   } fin_state_type;

endpackage : ip6tap_pkg
`default_nettype wire

// ===== rtl/ipv6_text_address_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_top
// Streaming IPv6 text address parser: one character in, one result per string.
// ----------------------------------------------------------------------------
// Feed the address text one character per req word; a zero character ends the
// string and produces exactly one rsp word carrying the ok flag on rsp_tuser
// and the 128-bit address on rsp_tdata (zero when not ok). Hex groups, one
// '::' gap and a dotted-quad IPv4 tail are handled; letters in either case.
// Rate: one character per clock, except for the stall described below. A
// character is registered in the input register when accepted and is folded
// into the parse state from there; the result is loaded into the output
// register when its terminating zero is folded in. The only stall is a
// terminating zero held in the input register while the previous result
// still waits in the output register. State returns to reset after every
// string; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_top
   import ip6tap_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] ch
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // [63:0] addr_hi, [127:64] addr_lo
   output logic              rsp_tuser    // [0] ok
);

   // ---------------------------------------------------------------- input
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_ch_ff;

   // ---------------------------------------------------------------- state
   phase_type        phase_ff, phase_in;
   logic [7:0][15:0] grp_ff;
   logic [3:0]       cnt_ff, cnt_in;
   logic [3:0]       gap_pos_ff, gap_pos_in;
   logic             gap_seen_ff, gap_seen_in;
   logic [15:0]      hex_ff, hex_in;
   logic [8:0]       dec_ff, dec_in;
   logic             letter_ff, letter_in;
   logic             digit_ff, digit_in;
   logic [1:0]       oct_idx_ff, oct_idx_in;
   logic [7:0]       oct_val_ff, oct_val_in;
   logic             oct_has_ff, oct_has_in;
   logic [2:0][7:0]  v4b_ff;
   logic             prev_colon_ff, prev_colon_in;

   logic             grp_we;
   logic             v4b_we;

   // ---------------------------------------------------------------- output
   logic             out_vld_ff, out_vld_in;
   logic [127:0]     out_data_ff;
   logic             out_ok_ff;

   // ---------------------------------------------------------------- decode
   logic        is_nul, is_colon, is_dot;
   logic        d_valid, is_dec;
   logic [3:0]  d_val;
   logic [12:0] dec_mul;
   logic [11:0] oct_mul;
   logic        hex_ok, v4_ok;
   logic        run_hex, run_v4, good;
   logic        proc, out_free;

   fin_state_type fin_st;
   logic          fin_ok;
   logic [63:0]   fin_hi, fin_lo;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if ((c >= "0") && (c <= "9")) begin
         r = {1'b1, 4'(c - "0")};
      end else if ((c >= "a") && (c <= "f")) begin
         r = {1'b1, 4'(c - "a" + 8'd10)};
      end else if ((c >= "A") && (c <= "F")) begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

   // Advance the input word when it can be folded in; a zero must find room.
   assign out_free   = !out_vld_ff || rsp_tready;
   assign is_nul     = (in_ch_ff == CH_NUL);
   assign proc       = in_vld_ff && (!is_nul || out_free);
   assign req_tready = !in_vld_ff || proc;

   assign is_colon = (in_ch_ff == CH_COLON);
   assign is_dot   = (in_ch_ff == CH_DOT);
   assign {d_valid, d_val} = hex_digit(in_ch_ff);
   assign is_dec   = d_valid && (d_val < 4'd10);

   assign dec_mul = 13'(dec_ff) * 13'd10 + 13'(d_val);
   assign oct_mul = 12'(oct_val_ff) * 12'd10 + 12'(d_val);

   // Whether a character is legal in the hex and in the IPv4 part.
   always_comb begin
      if (d_valid) begin
         hex_ok = (hex_ff[15:12] == 4'd0);
      end else if (is_colon) begin
         hex_ok = digit_ff ? (cnt_ff < 4'd8) : !gap_seen_ff;
      end else if (is_dot) begin
         hex_ok = (cnt_ff <= 4'd6) && digit_ff && !letter_ff && (dec_ff <= 9'd255);
      end else begin
         hex_ok = 1'b0;
      end

      if (is_dec) begin
         v4_ok = (oct_mul <= 12'd255);
      end else if (is_dot) begin
         v4_ok = oct_has_ff && (oct_idx_ff < 2'd3);
      end else begin
         v4_ok = 1'b0;
      end
   end

   // Phase outputs: which sub-parser runs and whether the character is good.
   always_comb begin
      run_hex = 1'b0;
      run_v4  = 1'b0;
      good    = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            run_hex = !is_colon;
            good    = is_colon || hex_ok;
         end
         PH_LEAD: begin
            run_hex = is_colon;
            good    = is_colon && hex_ok;
         end
         PH_HEX: begin
            run_hex = 1'b1;
            good    = hex_ok;
         end
         PH_V4: begin
            run_v4 = 1'b1;
            good   = v4_ok;
         end
         default: begin
            good = 1'b0;
         end
      endcase
   end

   // Phase next state.
   always_comb begin
      phase_in = phase_ff;
      if (proc) begin
         if (is_nul) begin
            phase_in = PH_START;
         end else if (!good) begin
            phase_in = PH_FAIL;
         end else if (run_hex && is_dot) begin
            phase_in = PH_V4;
         end else if ((phase_ff == PH_START) && is_colon) begin
            phase_in = PH_LEAD;
         end else if ((phase_ff == PH_START) || (phase_ff == PH_LEAD)) begin
            phase_in = PH_HEX;
         end
      end
   end

   // Token, group and octet updates; a bad character changes only phase and prev_colon.
   always_comb begin
      cnt_in        = cnt_ff;
      gap_pos_in    = gap_pos_ff;
      gap_seen_in   = gap_seen_ff;
      hex_in        = hex_ff;
      dec_in        = dec_ff;
      letter_in     = letter_ff;
      digit_in      = digit_ff;
      oct_idx_in    = oct_idx_ff;
      oct_val_in    = oct_val_ff;
      oct_has_in    = oct_has_ff;
      prev_colon_in = prev_colon_ff;
      grp_we        = 1'b0;
      v4b_we        = 1'b0;
      if (proc) begin
         if (is_nul) begin
            cnt_in        = 4'd0;
            gap_pos_in    = 4'd0;
            gap_seen_in   = 1'b0;
            hex_in        = 16'd0;
            dec_in        = 9'd0;
            letter_in     = 1'b0;
            digit_in      = 1'b0;
            oct_idx_in    = 2'd0;
            oct_val_in    = 8'd0;
            oct_has_in    = 1'b0;
            prev_colon_in = 1'b0;
         end else begin
            prev_colon_in = 1'b0;
            if (good && run_hex) begin
               if (d_valid) begin
                  hex_in   = {hex_ff[11:0], d_val};
                  digit_in = 1'b1;
                  if (is_dec) begin
                     dec_in = (dec_mul > 13'd255) ? 9'd256 : dec_mul[8:0];
                  end else begin
                     letter_in = 1'b1;
                  end
               end else if (is_colon) begin
                  hex_in    = 16'd0;
                  dec_in    = 9'd0;
                  letter_in = 1'b0;
                  digit_in  = 1'b0;
                  if (digit_ff) begin
                     grp_we        = 1'b1;
                     cnt_in        = cnt_ff + 4'd1;
                     prev_colon_in = 1'b1;
                  end else begin
                     gap_seen_in = 1'b1;
                     gap_pos_in  = cnt_ff;
                  end
               end else begin
                  // dot: first octet is the token read as decimal
                  oct_idx_in = 2'd1;
                  oct_val_in = 8'd0;
                  oct_has_in = 1'b0;
               end
            end else if (good && run_v4) begin
               if (is_dec) begin
                  oct_val_in = oct_mul[7:0];
                  oct_has_in = 1'b1;
               end else begin
                  v4b_we     = 1'b1;
                  oct_idx_in = oct_idx_ff + 2'd1;
                  oct_val_in = 8'd0;
                  oct_has_in = 1'b0;
               end
            end
         end
      end
   end

   // End-of-string check and gap expansion.
   always_comb begin
      fin_st.phase      = phase_ff;
      fin_st.grp        = grp_ff;
      fin_st.cnt        = cnt_ff;
      fin_st.gap_pos    = gap_pos_ff;
      fin_st.gap_seen   = gap_seen_ff;
      fin_st.hex        = hex_ff;
      fin_st.has_digit  = digit_ff;
      fin_st.prev_colon = prev_colon_ff;
      fin_st.oct_idx    = oct_idx_ff;
      fin_st.oct_val    = oct_val_ff;
      fin_st.oct_has    = oct_has_ff;
      fin_st.v4b        = v4b_ff;
   end

   ip6tap_finish u_finish (
      .st      (fin_st),
      .ok      (fin_ok),
      .addr_hi (fin_hi),
      .addr_lo (fin_lo)
   );

   // Hold the result until taken; load when a terminating zero is folded in.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (proc && is_nul) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         phase_ff      <= PH_START;
         cnt_ff        <= 4'd0;
         gap_pos_ff    <= 4'd0;
         gap_seen_ff   <= 1'b0;
         hex_ff        <= 16'd0;
         dec_ff        <= 9'd0;
         letter_ff     <= 1'b0;
         digit_ff      <= 1'b0;
         oct_idx_ff    <= 2'd0;
         oct_val_ff    <= 8'd0;
         oct_has_ff    <= 1'b0;
         prev_colon_ff <= 1'b0;
      end else begin
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         gap_pos_ff    <= gap_pos_in;
         gap_seen_ff   <= gap_seen_in;
         hex_ff        <= hex_in;
         dec_ff        <= dec_in;
         letter_ff     <= letter_in;
         digit_ff      <= digit_in;
         oct_idx_ff    <= oct_idx_in;
         oct_val_ff    <= oct_val_in;
         oct_has_ff    <= oct_has_in;
         prev_colon_ff <= prev_colon_in;
      end
   end

   // ---------------------------------------------------------------- payload regs
   // Group and octet stores are only read at entries written in this string.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
      end
      if (grp_we) begin
         grp_ff[cnt_ff[2:0]] <= hex_ff;
      end
      if (proc && !is_nul && good && run_hex && is_dot) begin
         v4b_ff[0] <= dec_ff[7:0];
      end
      if (v4b_we) begin
         v4b_ff[oct_idx_ff] <= oct_val_ff;
      end
      if (proc && is_nul) begin
         out_ok_ff   <= fin_ok;
         out_data_ff <= {fin_lo, fin_hi};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ok_ff;

   // ---------------------------------------------------------------- assertions
   a_notok_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 128'd0))
      else $error("rejected address carries nonzero data");

   a_clear_after_nul : assert property (@(posedge clock) disable iff (reset)
      (proc && is_nul) |=> ((phase_ff == PH_START) && (cnt_ff == 4'd0) && !gap_seen_ff))
      else $error("parse state not cleared after end of string");

   a_count_gap : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= 4'd8) && (!gap_seen_ff || (gap_pos_ff <= cnt_ff)))
      else $error("group count or gap position out of range");

   a_v4_room : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_V4) |-> ((cnt_ff <= 4'd6) && (oct_idx_ff != 2'd0)))
      else $error("IPv4 tail entered without room or octet index");

endmodule : ipv6_text_address_parser_top
`default_nettype wire

// ===== rtl/ip6tap_finish.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ip6tap_finish
// Closes a string: pushes the last token, checks lengths, expands the gap.
// ----------------------------------------------------------------------------
module ip6tap_finish
   import ip6tap_pkg::*;
(
   input  fin_state_type st,
   output logic          ok,
   output logic [63:0]   addr_hi,
   output logic [63:0]   addr_lo
);

   logic             push1;
   logic             push2;
   logic [15:0]      p1;
   logic [15:0]      p2;
   logic             fail_ph;
   logic             fail_len;
   logic [3:0]       n;
   logic [3:0]       tail;
   logic [7:0][15:0] eg;
   logic [7:0][15:0] g;

   // Close the open token or the IPv4 tail.
   always_comb begin
      push1   = 1'b0;
      push2   = 1'b0;
      p1      = st.hex;
      p2      = {st.v4b[2], st.oct_val};
      fail_ph = 1'b0;
      unique case (st.phase) inside
         PH_V4: begin
            fail_ph = !st.oct_has || (st.oct_idx != 2'd3) || (st.cnt > 4'd6);
            push1   = 1'b1;
            push2   = 1'b1;
            p1      = {st.v4b[0], st.v4b[1]};
         end
         PH_START, PH_HEX: begin
            fail_ph = st.prev_colon || (st.has_digit && (st.cnt >= 4'd8));
            push1   = st.has_digit;
         end
         default: begin
            fail_ph = 1'b1;
         end
      endcase
   end

   assign n    = st.cnt + {3'd0, push1} + {3'd0, push2};
   assign tail = n - st.gap_pos;

   always_comb begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
         eg[i] = st.grp[i];
         if (push1 && (4'(i) == st.cnt)) begin
            eg[i] = p1;
         end
         if (push2 && (4'(i) == (st.cnt + 4'd1))) begin
            eg[i] = p2;
         end
      end
   end

   assign fail_len = st.gap_seen ? ((n >= 4'd8) || (st.gap_pos > n)) : (n != 4'd8);

   // Head groups stay, tail groups slide to the end, the gap reads zero.
   always_comb begin
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         idx = 3'(i) + n[2:0];
         if (!st.gap_seen || (4'(i) < st.gap_pos)) begin
            g[i] = eg[i];
         end else if ((5'(i) + {1'b0, tail}) >= 5'd8) begin
            g[i] = eg[idx];
         end else begin
            g[i] = 16'd0;
         end
      end
   end

   assign ok      = !fail_ph && !fail_len;
   assign addr_hi = ok ? {g[0], g[1], g[2], g[3]} : 64'd0;
   assign addr_lo = ok ? {g[4], g[5], g[6], g[7]} : 64'd0;

endmodule : ip6tap_finish
`default_nettype wire

// ===== sim/tb_ipv6_text_address_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv6_text_address_parser_top
// Self-checking bench for the streaming IPv6 text address parser.
// ----------------------------------------------------------------------------
// Feeds address texts one character per req word. Starts with a table of
// hand-picked texts, then runs random texts, mostly well-formed with random
// content and some mangled or pure noise. A software copy of the parser folds
// every accepted character and queues the address it expects for each zero
// character. Every rsp word is checked field by field against the oldest
// queued address. The run walks through several idle/stall mixes and one long
// receiver hold-off that backs the parser up into its input.
// ----------------------------------------------------------------------------
module tb_ipv6_text_address_parser_top
   import ip6tap_pkg::*;
();

   // run shape
   localparam int NUM_PHASES      = 5;
   localparam int PRESSURE_PHASE  = 4;
   localparam int CHARS_PER_PHASE = 280;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;
   // idle/stall mix per phase, in percent of cycles
   localparam int REQ_IDLE_PCT [NUM_PHASES]  = '{0, 84, 0, 24, 0};
   localparam int RSP_STALL_PCT [NUM_PHASES] = '{0, 0, 84, 24, 0};

   typedef struct packed {
      logic        ok;
      logic [63:0] hi;
      logic [63:0] lo;
   } addr_result_type;

   typedef struct {
      string           text;
      bit              typed;
      addr_result_type want;
   } text_case_type;

   localparam addr_result_type REJECTED = '0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] ch
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;           // [63:0] addr_hi, [127:64] addr_lo
   logic         rsp_tuser;           // [0] ok

   // shared bench state
   addr_result_type pending_addrs [$];   // addresses owed by the parser, oldest first
   text_case_type   sample_texts [$];
   logic [7:0]      text_buf [$];        // text being sent, without its zero
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              chars_sent = 0;
   int              errors = 0;
   int              quiet_cycles = 0;
   bit              rsp_hold_on = 1'b0;
   event            rsp_hold_go;

   // software parser state
   phase_type         scan_phase;
   logic [7:0][15:0]  grp_mem;
   int                grp_cnt;
   int                gap_at;
   bit                gap_flag;
   logic [15:0]       hex_acc;
   int                dec_acc;        // saturates at 256
   bit                tok_letter;
   bit                tok_digit;
   int                oct_idx;
   int                oct_val;
   bit                oct_digit;
   logic [7:0]        v4_bytes [3];
   bit                after_group_colon;

   ipv6_text_address_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Software parser
   // ------------------------------------------------------------------------
   function automatic void clear_token();
      hex_acc    = 16'h0;
      dec_acc    = 0;
      tok_letter = 1'b0;
      tok_digit  = 1'b0;
   endfunction

   function automatic void clear_parser();
      scan_phase        = PH_START;
      grp_mem           = '0;
      grp_cnt           = 0;
      gap_at            = 0;
      gap_flag          = 1'b0;
      oct_idx           = 0;
      oct_val           = 0;
      oct_digit         = 1'b0;
      after_group_colon = 1'b0;
      foreach (v4_bytes[k]) v4_bytes[k] = 8'h00;
      clear_token();
   endfunction

   // Append one finished group; fails once eight are stored.
   function automatic bit push_group(logic [15:0] grp);
      if (grp_cnt >= NUM_GROUPS) return 1'b0;
      grp_mem[grp_cnt] = grp;
      grp_cnt++;
      return 1'b1;
   endfunction

   // One character while reading hex groups; 0 means the text is rejected.
   function automatic bit hex_step(logic [7:0] c);
      int d;
      int v;
      d = -1;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      if (d >= 0) begin
         // a fifth significant digit overflows the group
         if (hex_acc[15:12] != 4'h0) return 1'b0;
         hex_acc = {hex_acc[11:0], 4'(d)};
         if (d < 10) begin
            v = dec_acc * 10 + d;
            dec_acc = (v > 255) ? 256 : v;
         end else begin
            tok_letter = 1'b1;
         end
         tok_digit = 1'b1;
         return 1'b1;
      end
      if (c == CH_COLON) begin
         if (!tok_digit) begin
            // empty token: this colon opens the gap
            if (gap_flag) return 1'b0;
            gap_flag = 1'b1;
            gap_at   = grp_cnt;
            clear_token();
            return 1'b1;
         end
         if (!push_group(hex_acc)) return 1'b0;
         clear_token();
         after_group_colon = 1'b1;
         return 1'b1;
      end
      if (c == CH_DOT) begin
         // token so far becomes the first octet of the IPv4 tail
         if (grp_cnt > 6 || !tok_digit || tok_letter || dec_acc > 255) return 1'b0;
         v4_bytes[0] = 8'(dec_acc);
         oct_idx     = 1;
         oct_val     = 0;
         oct_digit   = 1'b0;
         scan_phase  = PH_V4;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Fold one character; returns 1 when it closes the text and fills res.
   function automatic bit fold_char(logic [7:0] c, output addr_result_type res);
      logic [7:0][15:0] g;
      bit fine;
      bit good;
      int n;
      int v;
      res  = REJECTED;
      g    = '0;
      good = 1'b1;
      if (c == CH_NUL) begin
         fine = 1'b1;
         if (scan_phase == PH_V4) begin
            fine = oct_digit && (oct_idx == 3);
            if (fine) fine = push_group({v4_bytes[0], v4_bytes[1]});
            if (fine) fine = push_group({v4_bytes[2], 8'(oct_val)});
         end else if (scan_phase == PH_HEX || scan_phase == PH_START) begin
            fine = !after_group_colon;
            if (fine && tok_digit) fine = push_group(hex_acc);
         end else begin
            fine = 1'b0;
         end
         n = grp_cnt;
         if (fine && gap_flag) begin
            // expand the gap into zero groups
            fine = (n < NUM_GROUPS) && (gap_at <= n);
            if (fine) begin
               for (int i = 0; i < NUM_GROUPS; i++) begin
                  if (i < gap_at) g[i] = grp_mem[i];
                  else if (i >= NUM_GROUPS - (n - gap_at))
                     g[i] = grp_mem[(i - (NUM_GROUPS - n)) & 7];
                  else g[i] = 16'h0;
               end
            end
         end else if (fine) begin
            fine = (n == NUM_GROUPS);
            g = grp_mem;
         end
         if (fine) begin
            res.ok = 1'b1;
            res.hi = {g[0], g[1], g[2], g[3]};
            res.lo = {g[4], g[5], g[6], g[7]};
         end
         clear_parser();
         return 1'b1;
      end
      after_group_colon = 1'b0;
      case (scan_phase)
         PH_START: begin
            if (c == CH_COLON) begin
               scan_phase = PH_LEAD;
            end else begin
               scan_phase = PH_HEX;
               good = hex_step(c);
            end
         end
         PH_LEAD: begin
            // a leading colon must be doubled
            scan_phase = PH_HEX;
            good = (c == CH_COLON) ? hex_step(c) : 1'b0;
         end
         PH_HEX: good = hex_step(c);
         PH_V4: begin
            if (c >= "0" && c <= "9") begin
               v = oct_val * 10 + (c - "0");
               good = (v <= 255);
               if (good) begin
                  oct_val   = v;
                  oct_digit = 1'b1;
               end
            end else if (c == CH_DOT && oct_digit && oct_idx < 3) begin
               v4_bytes[oct_idx] = 8'(oct_val);
               oct_idx++;
               oct_val   = 0;
               oct_digit = 1'b0;
            end else begin
               good = 1'b0;
            end
         end
         default: good = 1'b0;
      endcase
      if (!good) scan_phase = PH_FAIL;
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Text builders
   // ------------------------------------------------------------------------
   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
   endfunction

   // Mostly one to four digits; now and then five or six (leading zeros or
   // an overflowing group).
   function automatic void push_hex_group();
      int len;
      len = ($urandom_range(19) == 0) ? $urandom_range(6, 5) : $urandom_range(4, 1);
      repeat (len) text_buf.push_back(random_hex_digit());
   endfunction

   function automatic void add_row(string text, bit typed, addr_result_type want);
      text_case_type row;
      row.text  = text;
      row.typed = typed;
      row.want  = want;
      sample_texts.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   // Offer one character; fold it into the software parser once accepted and
   // queue the owed address when it is the closing zero.
   task automatic send_char(logic [7:0] ch, bit typed, addr_result_type want);
      addr_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (fold_char(ch, predicted)) pending_addrs.push_back(typed ? want : predicted);
      chars_sent++;
   endtask

   // Send text_buf followed by the terminating zero.
   task automatic send_text(bit typed, addr_result_type want);
      foreach (text_buf[k]) send_char(text_buf[k], 1'b0, REJECTED);
      send_char(CH_NUL, typed, want);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off when asked for
   // ------------------------------------------------------------------------
   initial begin : rsp_hold
      forever begin
         @(rsp_hold_go);
         rsp_hold_on = 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold_on = 1'b0;
      end
   end

   task automatic check_address_word();
      addr_result_type want;
      if (pending_addrs.size() == 0) begin
         $display("%0t: unexpected rsp word: expected none, actual ok=%0b tdata=%h",
                  $time, rsp_tuser, rsp_tdata);
         errors++;
      end else begin
         want = pending_addrs.pop_front();
         if (rsp_tuser !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b",
                     $time, want.ok, rsp_tuser);
            errors++;
         end
         if (rsp_tdata[63:0] !== want.hi) begin
            $display("%0t: addr_hi mismatch: expected %h, actual %h",
                     $time, want.hi, rsp_tdata[63:0]);
            errors++;
         end
         if (rsp_tdata[127:64] !== want.lo) begin
            $display("%0t: addr_lo mismatch: expected %h, actual %h",
                     $time, want.lo, rsp_tdata[127:64]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_address_word();
      rsp_tready <= !rsp_hold_on && ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when no word moves for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int mark;
      int r;
      int slots;
      int named_groups;
      int left;
      int v;
      int pos;
      int len;
      int pick;
      bit with_v4;

      clear_parser();

      // Hand-picked texts; expected address typed in where it is obvious,
      // otherwise left to the software parser.
      add_row("", 1'b1, REJECTED);                                   // empty text
      add_row("::", 1'b1, '{1'b1, 64'h0, 64'h0});
      add_row("::1", 1'b1, '{1'b1, 64'h0, 64'h1});
      add_row("1::", 1'b1, '{1'b1, 64'h0001_0000_0000_0000, 64'h0});
      add_row("ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff", 1'b1,
              '{1'b1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
      add_row("FfFf:ABCD:0:1:2:3:4:5", 1'b0, REJECTED);              // mixed case
      add_row("2001:DB8:aBc::7:0.0.0.0", 1'b0, REJECTED);
      add_row(":1", 1'b1, REJECTED);                                 // lone leading colon
      add_row(":", 1'b1, REJECTED);
      add_row("1:", 1'b1, REJECTED);                                 // trailing colon
      add_row("1::2::3", 1'b1, REJECTED);                            // second gap
      add_row("1:::2", 1'b1, REJECTED);
      add_row("10000::", 1'b1, REJECTED);                            // group overflow
      add_row("00000ffff::", 1'b0, REJECTED);                        // leading zeros fit
      add_row("1:2:3:4:5:6:7:8:9", 1'b1, REJECTED);                  // ninth group
      add_row("1:2:3:4:5:6:7:8::", 1'b1, REJECTED);                  // gap with eight
      add_row("1:2:3", 1'b1, REJECTED);                              // too few groups
      add_row("::1.2.3.4", 1'b0, REJECTED);
      add_row("::ffff:255.255.255.255", 1'b0, REJECTED);
      add_row("1:2:3:4:5:6:000.001.002.003", 1'b0, REJECTED);
      add_row("::256.1.1.1", 1'b1, REJECTED);                        // octet over 255
      add_row("::1.2.3.256", 1'b1, REJECTED);
      add_row("::1.2.3", 1'b1, REJECTED);                            // three octets
      add_row("::1.2.3.4.5", 1'b1, REJECTED);
      add_row("1:2:3:4:5:6:7:1.2.3.4", 1'b1, REJECTED);              // no room for tail
      add_row("::a.1.2.3", 1'b1, REJECTED);
      add_row("::1.2.3.4x", 1'b1, REJECTED);
      add_row("1::g", 1'b1, REJECTED);                               // stray character

      // hold reset, then release it once
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (sample_texts[j]) begin
         text_buf.delete();
         for (int i = 0; i < sample_texts[j].text.len(); i++)
            text_buf.push_back(sample_texts[j].text[i]);
         send_text(sample_texts[j].typed, sample_texts[j].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         req_idle_pct  = REQ_IDLE_PCT[p];
         rsp_stall_pct = RSP_STALL_PCT[p];
         // full-rate sender against a receiver that stops dead for a while
         if (p == PRESSURE_PHASE) -> rsp_hold_go;
         mark = chars_sent;
         while (chars_sent - mark < CHARS_PER_PHASE) begin
            text_buf.delete();
            r = $urandom_range(9);
            if (r == 0) begin
               // noise: separators, hex digits and arbitrary bytes
               len = $urandom_range(12);
               repeat (len) begin
                  pick = $urandom_range(3);
                  case (pick)
                     0:       text_buf.push_back(CH_COLON);
                     1:       text_buf.push_back(CH_DOT);
                     2:       text_buf.push_back(8'($urandom_range(255, 1)));
                     default: text_buf.push_back(random_hex_digit());
                  endcase
               end
            end else begin
               // well-formed shape with random content
               with_v4 = ($urandom_range(3) == 0);
               slots   = with_v4 ? 6 : 8;
               if ($urandom_range(4) < 3) begin
                  // with a gap; now and then one group too many
                  named_groups = ($urandom_range(9) == 0) ? slots
                                                          : $urandom_range(slots - 1);
                  left = $urandom_range(named_groups);
                  for (int i = 0; i < left; i++) begin
                     if (i != 0) text_buf.push_back(CH_COLON);
                     push_hex_group();
                  end
                  text_buf.push_back(CH_COLON);
                  text_buf.push_back(CH_COLON);
                  for (int i = 0; i < named_groups - left; i++) begin
                     if (i != 0) text_buf.push_back(CH_COLON);
                     push_hex_group();
                  end
                  if (with_v4 && named_groups > left) text_buf.push_back(CH_COLON);
               end else begin
                  for (int i = 0; i < slots; i++) begin
                     if (i != 0) text_buf.push_back(CH_COLON);
                     push_hex_group();
                  end
                  if (with_v4) text_buf.push_back(CH_COLON);
               end
               if (with_v4) begin
                  for (int k = 0; k < 4; k++) begin
                     if (k != 0) text_buf.push_back(CH_DOT);
                     v = ($urandom_range(29) == 0) ? $urandom_range(999, 256)
                                                   : $urandom_range(255);
                     if ($urandom_range(7) == 0)
                        repeat ($urandom_range(2, 1)) text_buf.push_back("0");
                     if (v >= 100) text_buf.push_back(8'("0" + v / 100));
                     if (v >= 10) text_buf.push_back(8'("0" + (v / 10) % 10));
                     text_buf.push_back(8'("0" + v % 10));
                  end
               end
               if (r <= 3) begin
                  // break the shape: overwrite, drop or insert one character
                  pos = $urandom_range(text_buf.size() - 1);
                  case ($urandom_range(2))
                     0:       text_buf[pos] = 8'($urandom_range(255, 1));
                     1:       text_buf.delete(pos);
                     default: text_buf.insert(pos, $urandom_range(1) ? CH_COLON : CH_DOT);
                  endcase
               end
            end
            send_text(1'b0, REJECTED);
         end
         // drop valid and drain before the next mix
         req_tvalid <= 1'b0;
         while (pending_addrs.size() != 0) @(posedge clock);
      end

      // watch for stray words past the last address
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_addrs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
